// ===== hdl/tchc_pkg.sv =====
`default_nettype none
package tchc_pkg;

	localparam int TABLE_LEN  = 24;
	localparam int SQRT_STEPS = 32;
	localparam int DIV_STEPS  = 31;

	localparam logic [31:0] TWO_PI_Q29 = 32'hC90F_DAA2;
	localparam logic [31:0] RECIP3     = 32'hAAAA_AAAB;
	localparam logic [16:0] FRAC_ONE   = 17'h1_0000;

	localparam logic [31:0] ATAN_TURNS [TABLE_LEN] = '{
		32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4, 32'h028B_0D43,
		32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55, 32'h0028_BE53, 32'h0014_5F2F,
		32'h000A_2F98, 32'h0005_17CC, 32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA,
		32'h0000_517D, 32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
		32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051
	};

	typedef enum logic [1:0] {
		REG_MAX_PUSH      = 2'd0,
		REG_NOZZLE_OFFSET = 2'd1,
		REG_MAX_TURN_RATE = 2'd2
	} tchc_reg_t;

	typedef struct packed {
		logic signed [31:0] steer_x;
		logic signed [31:0] steer_y;
		logic [30:0]        body_mass;
		logic [15:0]        body_heading;
		logic signed [31:0] spin_rate;
		logic [30:0]        body_inertia;
	} tchc_req_t;

	typedef struct packed {
		logic signed [31:0] push_x;
		logic signed [31:0] push_y;
		logic [16:0]        thrust_fraction;
		logic signed [31:0] turn_impulse;
	} tchc_rsp_t;

endpackage
`default_nettype wire

// ===== hdl/tchc_isqrt.sv =====
`default_nettype none
module tchc_isqrt #(
	parameter int SB_W = 1
) (
	input  wire logic            clk,
	input  wire logic            en,
	input  wire logic [63:0]     rad,
	input  wire logic [SB_W-1:0] sb_in,
	output logic [31:0]          root,
	output logic [SB_W-1:0]      sb_out
);
	import tchc_pkg::*;

	logic [63:0]     rad_s  [0:SQRT_STEPS-1];
	logic [33:0]     rem_s  [0:SQRT_STEPS-1];
	logic [31:0]     root_s [0:SQRT_STEPS-1];
	logic [SB_W-1:0] sb_s   [0:SQRT_STEPS-1];

	for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_step
		logic [63:0]     rad_c;
		logic [33:0]     rem_c;
		logic [31:0]     root_c;
		logic [SB_W-1:0] sb_c;
		logic [35:0]     cur;
		logic [35:0]     trial;

		if (g == 0) begin : g_first
			assign rad_c  = rad;
			assign rem_c  = '0;
			assign root_c = '0;
			assign sb_c   = sb_in;
		end else begin : g_next
			assign rad_c  = rad_s[g-1];
			assign rem_c  = rem_s[g-1];
			assign root_c = root_s[g-1];
			assign sb_c   = sb_s[g-1];
		end

		assign cur   = {rem_c, rad_c[63:62]};
		assign trial = {2'b00, root_c, 2'b01};

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[g] <= {rad_c[61:0], 2'b00};
				sb_s[g]  <= sb_c;
				if (cur >= trial) begin
					rem_s[g]  <= 34'(cur - trial);
					root_s[g] <= {root_c[30:0], 1'b1};
				end else begin
					rem_s[g]  <= cur[33:0];
					root_s[g] <= {root_c[30:0], 1'b0};
				end
			end
		end
	end

	assign root   = root_s[SQRT_STEPS-1];
	assign sb_out = sb_s[SQRT_STEPS-1];

endmodule
`default_nettype wire

// ===== hdl/tchc_div.sv =====
`default_nettype none
module tchc_div #(
	parameter int SB_W = 1
) (
	input  wire logic            clk,
	input  wire logic            en,
	input  wire logic [62:0]     num,
	input  wire logic [31:0]     den,
	input  wire logic [SB_W-1:0] sb_in,
	output logic [30:0]          quo,
	output logic [SB_W-1:0]      sb_out
);
	import tchc_pkg::*;

	logic [30:0]     low_s [0:DIV_STEPS-1];
	logic [31:0]     rem_s [0:DIV_STEPS-1];
	logic [31:0]     den_s [0:DIV_STEPS-1];
	logic [30:0]     quo_s [0:DIV_STEPS-1];
	logic [SB_W-1:0] sb_s  [0:DIV_STEPS-1];

	for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
		logic [30:0]     low_c;
		logic [31:0]     rem_c;
		logic [31:0]     den_c;
		logic [30:0]     quo_c;
		logic [SB_W-1:0] sb_c;
		logic [32:0]     cur;

		if (g == 0) begin : g_first
			assign low_c = num[30:0];
			assign rem_c = num[62:31];
			assign den_c = den;
			assign quo_c = '0;
			assign sb_c  = sb_in;
		end else begin : g_next
			assign low_c = low_s[g-1];
			assign rem_c = rem_s[g-1];
			assign den_c = den_s[g-1];
			assign quo_c = quo_s[g-1];
			assign sb_c  = sb_s[g-1];
		end

		assign cur = {rem_c, low_c[30]};

		always_ff @(posedge clk) begin
			if (en) begin
				low_s[g] <= {low_c[29:0], 1'b0};
				den_s[g] <= den_c;
				sb_s[g]  <= sb_c;
				if (cur >= {1'b0, den_c}) begin
					rem_s[g] <= 32'(cur - {1'b0, den_c});
					quo_s[g] <= {quo_c[29:0], 1'b1};
				end else begin
					rem_s[g] <= cur[31:0];
					quo_s[g] <= {quo_c[29:0], 1'b0};
				end
			end
		end
	end

	assign quo    = quo_s[DIV_STEPS-1];
	assign sb_out = sb_s[DIV_STEPS-1];

endmodule
`default_nettype wire

// ===== hdl/tchc_heading.sv =====
`default_nettype none
module tchc_heading #(
	parameter int STEPS = 16
) (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic signed [31:0] steer_x,
	input  wire logic signed [31:0] steer_y,
	input  wire logic [15:0]        body_heading,
	input  wire logic signed [31:0] spin_rate,
	input  wire logic [30:0]        body_inertia,
	input  wire logic [15:0]        nozzle_offset,
	input  wire logic [30:0]        max_turn_rate,
	output logic signed [31:0]      turn_impulse
);
	import tchc_pkg::*;

	// sideband: zero vector, spin sign, spin/3, heading, inertia
	localparam int SB_W = 1 + 1 + 31 + 16 + 31;

	logic signed [34:0] x_s  [0:STEPS];
	logic signed [34:0] y_s  [0:STEPS];
	logic [31:0]        a_s  [0:STEPS];
	logic [SB_W-1:0]    sb_s [0:STEPS];

	logic [31:0]        spin_abs;
	logic [63:0]        spin_prod;
	logic               xneg;

	assign spin_abs  = spin_rate[31] ? 32'(-spin_rate) : 32'(spin_rate);
	assign spin_prod = spin_abs * RECIP3;
	assign xneg      = steer_x[31];

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]  <= xneg ? -35'(steer_x) : 35'(steer_x);
			y_s[0]  <= xneg ? -35'(steer_y) : 35'(steer_y);
			a_s[0]  <= xneg ? 32'h8000_0000 : 32'h0;
			sb_s[0] <= {(steer_x == 32'sd0) && (steer_y == 32'sd0), spin_rate[31],
				spin_prod[63:33], body_heading, body_inertia};
		end
	end

	// vectoring steps
	for (genvar g = 0; g < STEPS; g++) begin : g_cordic
		logic signed [34:0] dx;
		logic signed [34:0] dy;

		assign dx = y_s[g] >>> g;
		assign dy = x_s[g] >>> g;

		always_ff @(posedge clk) begin
			if (en) begin
				sb_s[g+1] <= sb_s[g];
				if (y_s[g] > 35'sd0) begin
					x_s[g+1] <= x_s[g] + dx;
					y_s[g+1] <= y_s[g] - dy;
					a_s[g+1] <= a_s[g] + ATAN_TURNS[g];
				end else begin
					x_s[g+1] <= x_s[g] - dx;
					y_s[g+1] <= y_s[g] + dy;
					a_s[g+1] <= a_s[g] - ATAN_TURNS[g];
				end
			end
		end
	end

	logic               zero_c;
	logic               sneg_c;
	logic [30:0]        sq3_c;
	logic [15:0]        hd_c;
	logic [30:0]        inr_c;
	logic [31:0]        ang_c;
	logic [31:0]        lead_c;

	assign {zero_c, sneg_c, sq3_c, hd_c, inr_c} = sb_s[STEPS];
	assign ang_c  = zero_c ? 32'h0 : a_s[STEPS];
	assign lead_c = sneg_c ? -{1'b0, sq3_c} : {1'b0, sq3_c};

	logic signed [31:0] err_e;
	logic [30:0]        inr_e;

	always_ff @(posedge clk) begin
		if (en) begin
			err_e <= ang_c - {hd_c, 16'h0} + {nozzle_offset, 16'h0} - lead_c;
			inr_e <= inr_c;
		end
	end

	// error times 60, clamped to the turn rate limit
	logic signed [37:0] err_w;
	logic signed [37:0] rate_w;
	logic signed [37:0] lim_w;
	logic signed [37:0] rate_c;

	assign err_w  = 38'(err_e);
	assign rate_w = (err_w <<< 6) - (err_w <<< 2);
	assign lim_w  = {7'b0, max_turn_rate};

	always_comb begin
		rate_c = rate_w;
		if (rate_w > lim_w)
			rate_c = lim_w;
		if (rate_w < -lim_w)
			rate_c = -lim_w;
	end

	logic [30:0] mag_r;
	logic        neg_r;
	logic [30:0] inr_r;

	always_ff @(posedge clk) begin
		if (en) begin
			mag_r <= rate_c[37] ? 31'(-rate_c) : rate_c[30:0];
			neg_r <= rate_c[37];
			inr_r <= inr_e;
		end
	end

	logic [61:0] prod_p;
	logic        neg_p;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_p <= inr_r * mag_r;
			neg_p  <= neg_r;
		end
	end

	logic [61:0] hi_m;
	logic [63:0] lo_w;
	logic [31:0] lo_m;
	logic        neg_m;

	assign lo_w = prod_p[31:0] * TWO_PI_Q29;

	always_ff @(posedge clk) begin
		if (en) begin
			hi_m  <= prod_p[61:32] * TWO_PI_Q29;
			lo_m  <= lo_w[63:32];
			neg_m <= neg_p;
		end
	end

	logic [62:0] sum_c;
	logic [33:0] scaled_c;

	assign sum_c    = {1'b0, hi_m} + {31'b0, lo_m};
	assign scaled_c = sum_c[62:29];

	always_ff @(posedge clk) begin
		if (en) begin
			if (!neg_m)
				turn_impulse <= (scaled_c > 34'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF
					: $signed(scaled_c[31:0]);
			else
				turn_impulse <= (scaled_c > 34'h0_8000_0000) ? 32'sh8000_0000
					: $signed(-scaled_c[31:0]);
		end
	end

endmodule
`default_nettype wire

// ===== hdl/thrust_clamp_heading_control_core.sv =====
`default_nettype none
// Steering to impulse core. Each beat on req (steering vector, mass, heading,
// spin, inertia) yields one beat on rsp with the linear impulse, clamped to
// max_push, the thrust fraction and the angular impulse toward the steering
// direction. One beat is accepted per clock while rsp is not stalled. Length
// scaling and the thrust fraction run through the 32-step square root and the
// 31-step divider; the heading path (CORDIC of ARCTAN_STEPS stages) is delayed
// to match. A stalled rsp holds the whole pipeline and raises req_stall. The
// user must write the registers through cfg (0 max_push, 1 nozzle_offset,
// 2 max_turn_rate) only while no beat is in flight; not enforced by the core.
module thrust_clamp_heading_control_core #(
	parameter int ARCTAN_STEPS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_stall,
	input  wire tchc_pkg::tchc_req_t req,
	output logic                    rsp_valid,
	input  wire logic               rsp_stall,
	output tchc_pkg::tchc_rsp_t     rsp,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [31:0]        cfg_data
);
	import tchc_pkg::*;

	localparam int MAG_LAT  = 3 + SQRT_STEPS + 1 + DIV_STEPS;
	localparam int HEAD_LAT = ARCTAN_STEPS + 6;
	localparam int DLY      = MAG_LAT - HEAD_LAT;

	// configuration
	logic [30:0] max_push_q;
	logic [15:0] nozzle_offset_q;
	logic [30:0] max_turn_rate_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_push_q      <= '0;
			nozzle_offset_q <= '0;
			max_turn_rate_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MAX_PUSH:      max_push_q      <= cfg_data[30:0];
				REG_NOZZLE_OFFSET: nozzle_offset_q <= cfg_data[15:0];
				REG_MAX_TURN_RATE: max_turn_rate_q <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// pipeline control
	logic               en;
	logic [MAG_LAT-1:0] vld_q;

	assign en        = !(rsp_valid && rsp_stall);
	assign req_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rsp_valid <= 1'b0;
		end else if (en) begin
			vld_q     <= {vld_q[MAG_LAT-2:0], req_valid};
			rsp_valid <= vld_q[MAG_LAT-1];
		end
	end

	// stage 1: mass products and steering squares
	logic [31:0] absx_c;
	logic [31:0] absy_c;

	assign absx_c = req.steer_x[31] ? 32'(-req.steer_x) : 32'(req.steer_x);
	assign absy_c = req.steer_y[31] ? 32'(-req.steer_y) : 32'(req.steer_y);

	logic signed [63:0] mx_s1, my_s1;
	logic [63:0]        sxsq_s1, sysq_s1;
	logic [31:0]        absx_s1, absy_s1;
	logic               sxn_s1, syn_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s1   <= $signed({1'b0, req.body_mass}) * req.steer_x;
			my_s1   <= $signed({1'b0, req.body_mass}) * req.steer_y;
			sxsq_s1 <= absx_c * absx_c;
			sysq_s1 <= absy_c * absy_c;
			absx_s1 <= absx_c;
			absy_s1 <= absy_c;
			sxn_s1  <= req.steer_x[31];
			syn_s1  <= req.steer_y[31];
		end
	end

	// stage 2: impulse squares against the limit
	logic signed [47:0] ixw_c, iyw_c;
	logic [47:0]        axw_c, ayw_c;

	assign ixw_c = mx_s1[63:16];
	assign iyw_c = my_s1[63:16];
	assign axw_c = ixw_c[47] ? 48'(-ixw_c) : 48'(ixw_c);
	assign ayw_c = iyw_c[47] ? 48'(-iyw_c) : 48'(iyw_c);

	logic [61:0] axsq_s2, aysq_s2, mpsq_s2;
	logic [63:0] ssum_s2;
	logic        big_s2;
	logic [31:0] ix_s2, iy_s2, absx_s2, absy_s2;
	logic        sxn_s2, syn_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			axsq_s2 <= axw_c[30:0] * axw_c[30:0];
			aysq_s2 <= ayw_c[30:0] * ayw_c[30:0];
			mpsq_s2 <= max_push_q * max_push_q;
			ssum_s2 <= sxsq_s1 + sysq_s1;
			big_s2  <= (|axw_c[47:31]) || (|ayw_c[47:31]);
			ix_s2   <= ixw_c[31:0];
			iy_s2   <= iyw_c[31:0];
			absx_s2 <= absx_s1;
			absy_s2 <= absy_s1;
			sxn_s2  <= sxn_s1;
			syn_s2  <= syn_s1;
		end
	end

	// stage 3: too long decision, root operand
	logic [62:0] sumsq_c;

	assign sumsq_c = {1'b0, axsq_s2} + {1'b0, aysq_s2};

	logic [63:0] rad_s3;
	logic        tl_s3;
	logic [31:0] ix_s3, iy_s3, absx_s3, absy_s3;
	logic        sxn_s3, syn_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			tl_s3   <= big_s2 || (sumsq_c > {1'b0, mpsq_s2});
			rad_s3  <= (big_s2 || (sumsq_c > {1'b0, mpsq_s2})) ? ssum_s2 : {1'b0, sumsq_c};
			ix_s3   <= ix_s2;
			iy_s3   <= iy_s2;
			absx_s3 <= absx_s2;
			absy_s3 <= absy_s2;
			sxn_s3  <= sxn_s2;
			syn_s3  <= syn_s2;
		end
	end

	localparam int RSB_W = 3 + 4 * 32;

	logic [31:0]      root_c;
	logic [RSB_W-1:0] rsb_c;

	tchc_isqrt #(.SB_W(RSB_W)) u_isqrt (
		.clk    (clk),
		.en     (en),
		.rad    (rad_s3),
		.sb_in  ({tl_s3, sxn_s3, syn_s3, absx_s3, absy_s3, ix_s3, iy_s3}),
		.root   (root_c),
		.sb_out (rsb_c)
	);

	logic        tl_r, sxn_r, syn_r;
	logic [31:0] absx_r, absy_r, ix_r, iy_r;

	assign {tl_r, sxn_r, syn_r, absx_r, absy_r, ix_r, iy_r} = rsb_c;

	// stage 4: divider operands
	logic [62:0] nx_s4, ny_s4;
	logic [31:0] den_s4;
	logic        dz_s4, tl_s4, sxn_s4, syn_s4;
	logic [31:0] ix_s4, iy_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s4  <= tl_r ? absx_r * max_push_q : {15'b0, root_c, 16'h0};
			ny_s4  <= absy_r * max_push_q;
			den_s4 <= tl_r ? root_c : {1'b0, max_push_q};
			dz_s4  <= tl_r ? (root_c == 32'h0) : (max_push_q == 31'h0);
			tl_s4  <= tl_r;
			sxn_s4 <= sxn_r;
			syn_s4 <= syn_r;
			ix_s4  <= ix_r;
			iy_s4  <= iy_r;
		end
	end

	localparam int DSB_W = 3 + 2 * 32;

	logic [30:0]      qx_c, qy_c;
	logic [DSB_W-1:0] dsb_c;
	logic             syn_d;

	tchc_div #(.SB_W(DSB_W)) u_div_x (
		.clk    (clk),
		.en     (en),
		.num    (nx_s4),
		.den    (den_s4),
		.sb_in  ({tl_s4, sxn_s4, dz_s4, ix_s4, iy_s4}),
		.quo    (qx_c),
		.sb_out (dsb_c)
	);

	tchc_div #(.SB_W(1)) u_div_y (
		.clk    (clk),
		.en     (en),
		.num    (ny_s4),
		.den    (den_s4),
		.sb_in  (syn_s4),
		.quo    (qy_c),
		.sb_out (syn_d)
	);

	logic        tl_d, sxn_d, dz_d;
	logic [31:0] ix_d, iy_d;

	assign {tl_d, sxn_d, dz_d, ix_d, iy_d} = dsb_c;

	// heading path, delayed to line up with the divider output
	logic signed [31:0] head_imp;

	tchc_heading #(.STEPS(ARCTAN_STEPS)) u_heading (
		.clk           (clk),
		.en            (en),
		.steer_x       (req.steer_x),
		.steer_y       (req.steer_y),
		.body_heading  (req.body_heading),
		.spin_rate     (req.spin_rate),
		.body_inertia  (req.body_inertia),
		.nozzle_offset (nozzle_offset_q),
		.max_turn_rate (max_turn_rate_q),
		.turn_impulse  (head_imp)
	);

	logic signed [31:0] turn_dly_s [0:DLY-1];

	always_ff @(posedge clk) begin
		if (en) begin
			turn_dly_s[0] <= head_imp;
			for (int i = 1; i < DLY; i++)
				turn_dly_s[i] <= turn_dly_s[i-1];
		end
	end

	// output register
	logic [31:0] qx_w, qy_w;

	assign qx_w = dz_d ? 32'h0 : {1'b0, qx_c};
	assign qy_w = dz_d ? 32'h0 : {1'b0, qy_c};

	always_ff @(posedge clk) begin
		if (en) begin
			rsp.turn_impulse <= turn_dly_s[DLY-1];
			if (tl_d) begin
				rsp.push_x          <= sxn_d ? $signed(-qx_w) : $signed(qx_w);
				rsp.push_y          <= syn_d ? $signed(-qy_w) : $signed(qy_w);
				rsp.thrust_fraction <= FRAC_ONE;
			end else begin
				rsp.push_x <= $signed(ix_d);
				rsp.push_y <= $signed(iy_d);
				if (dz_d || ({1'b0, qx_c} > {15'b0, FRAC_ONE}))
					rsp.thrust_fraction <= FRAC_ONE;
				else
					rsp.thrust_fraction <= qx_c[16:0];
			end
		end
	end

endmodule
`default_nettype wire

// ===== hdl/tchc_checker.sv =====
`default_nettype none
module tchc_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                req_stall,
	input wire logic                rsp_valid,
	input wire logic                rsp_stall,
	input wire tchc_pkg::tchc_rsp_t rsp
);
	import tchc_pkg::*;

	// held beat stays put
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("rsp beat changed while stalled");

	a_back_pressure: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |-> req_stall)
		else $error("req taken while rsp blocked");

	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> !req_stall)
		else $error("req stalled with empty output");

	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.thrust_fraction <= FRAC_ONE)
		else $error("thrust fraction above one");

endmodule

bind thrust_clamp_heading_control_core tchc_checker u_tchc_checker (.*);
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top;
	import tchc_pkg::*;

	localparam int          CORDIC_STAGES = 16;
	localparam logic [1:0]  REG_UNUSED    = 2'd3;
	localparam int          LONG_HOLD     = 300;
	localparam int          SETTLE_CYCLES = 80;

	class impulse_scoreboard;
		logic [30:0] max_push;
		logic [15:0] nozzle_offset;
		logic [30:0] max_turn_rate;
		tchc_rsp_t   expected_q[$];
		int          mismatches;
		int          checked;
		int          clamped;

		function new();
			max_push      = '0;
			nozzle_offset = '0;
			max_turn_rate = '0;
			mismatches    = 0;
			checked       = 0;
			clamped       = 0;
		endfunction

		function void set_register(logic [1:0] idx, logic [31:0] data);
			case (idx)
				REG_MAX_PUSH: begin
					max_push = data[30:0];
				end
				REG_NOZZLE_OFFSET: begin
					nozzle_offset = data[15:0];
				end
				REG_MAX_TURN_RATE: begin
					max_turn_rate = data[30:0];
				end
				default: begin
				end
			endcase
		endfunction

		function longint unsigned int_sqrt(longint unsigned n);
			longint unsigned r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > n)
				b >>= 2;
			while (b != 0) begin
				if (n >= r + b) begin
					n -= r + b;
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			return r;
		endfunction

		function logic [31:0] vector_angle(longint x, longint y);
			logic [31:0] a;
			longint dx, dy;
			a = '0;
			if (x == 0 && y == 0)
				return '0;
			if (x < 0) begin
				x = -x;
				y = -y;
				a = 32'h8000_0000;
			end
			for (int i = 0; i < CORDIC_STAGES && i < TABLE_LEN; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (y > 0) begin
					x += dx;
					y -= dy;
					a += ATAN_TURNS[i];
				end else begin
					x -= dx;
					y += dy;
					a -= ATAN_TURNS[i];
				end
			end
			return a;
		endfunction

		function tchc_rsp_t predict_impulse(tchc_req_t r);
			tchc_rsp_t       o;
			longint          sx, sy, ix, iy, px, py, err, rate, lim, imp;
			longint unsigned ax, ay, mp, sumsq, slen, qx, qy, frac, mag, prod, hi, lo, scaled;
			longint unsigned asx, asy;
			logic [31:0]     e, lead;
			int              spin;
			bit              too_long;
			sx = longint'(r.steer_x);
			sy = longint'(r.steer_y);
			ix = (longint'(r.body_mass) * sx) >>> 16;
			iy = (longint'(r.body_mass) * sy) >>> 16;
			ax = ix < 0 ? -ix : ix;
			ay = iy < 0 ? -iy : iy;
			mp = max_push;
			sumsq = 0;
			too_long = 0;
			if (ax >= 64'h8000_0000 || ay >= 64'h8000_0000) begin
				too_long = 1;
			end else begin
				sumsq = ax * ax + ay * ay;
				if (sumsq > mp * mp)
					too_long = 1;
			end
			if (too_long) begin
				asx  = sx < 0 ? -sx : sx;
				asy  = sy < 0 ? -sy : sy;
				slen = int_sqrt(asx * asx + asy * asy);
				qx   = slen != 0 ? asx * mp / slen : 0;
				qy   = slen != 0 ? asy * mp / slen : 0;
				px   = sx < 0 ? -longint'(qx) : longint'(qx);
				py   = sy < 0 ? -longint'(qy) : longint'(qy);
				frac = 65536;
				clamped++;
			end else begin
				px = ix;
				py = iy;
				if (mp == 0) begin
					frac = 65536;
				end else begin
					frac = (int_sqrt(sumsq) << 16) / mp;
					if (frac > 65536)
						frac = 65536;
				end
			end
			spin = r.spin_rate;
			lead = spin / 3;
			e = vector_angle(sx, sy) - {r.body_heading, 16'h0} + {nozzle_offset, 16'h0} - lead;
			err = longint'(signed'(e));
			rate = err * 60;
			lim = longint'(max_turn_rate);
			if (rate > lim)
				rate = lim;
			if (rate < -lim)
				rate = -lim;
			mag    = rate < 0 ? -rate : rate;
			prod   = longint'(r.body_inertia) * mag;
			hi     = prod >> 32;
			lo     = prod & 64'hFFFF_FFFF;
			scaled = (hi * TWO_PI_Q29 + ((lo * TWO_PI_Q29) >> 32)) >> 29;
			if (rate >= 0)
				imp = scaled > 64'h7FFF_FFFF ? 64'sh7FFF_FFFF : longint'(scaled);
			else
				imp = scaled > 64'h8000_0000 ? -64'sh8000_0000 : -longint'(scaled);
			o.push_x          = px[31:0];
			o.push_y          = py[31:0];
			o.thrust_fraction = frac[16:0];
			o.turn_impulse    = imp[31:0];
			return o;
		endfunction

		function void note_request(tchc_req_t r);
			expected_q.push_back(predict_impulse(r));
		endfunction

		function void check_response(tchc_rsp_t got);
			tchc_rsp_t want;
			checked++;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat %h", got);
				return;
			end
			want = expected_q.pop_front();
			if (got.push_x !== want.push_x || got.push_y !== want.push_y
					|| got.thrust_fraction !== want.thrust_fraction
					|| got.turn_impulse !== want.turn_impulse) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch beat %0d: exp x %h y %h frac %h turn %h, got x %h y %h frac %h turn %h",
						checked, want.push_x, want.push_y, want.thrust_fraction,
						want.turn_impulse, got.push_x, got.push_y, got.thrust_fraction,
						got.turn_impulse);
			end
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_stall;
	tchc_req_t req;
	logic      rsp_valid;
	logic      rsp_stall;
	tchc_rsp_t rsp;
	logic      cfg_valid;
	logic      cfg_ready;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	impulse_scoreboard sb;
	bit  hold_go;
	int  burst_left;
	int  items_sent;

	thrust_clamp_heading_control_core #(.ARCTAN_STEPS(CORDIC_STAGES)) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// result beats are sampled mid-cycle, away from the driving edge
	always @(negedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_response(rsp);
	end

	// receiver stall pattern, with an optional long hold
	initial begin : receiver
		int hold_left, seg_left, mode;
		hold_left = 0;
		seg_left  = 0;
		mode      = 0;
		rsp_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_go) begin
				hold_go   = 0;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else begin
				if (seg_left == 0) begin
					mode     = $urandom_range(0, 2);
					seg_left = $urandom_range(10, 60);
				end
				seg_left--;
				case (mode)
					0: rsp_stall <= 1'b0;
					1: rsp_stall <= ($urandom_range(0, 3) == 0);
					default: rsp_stall <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	initial begin : watchdog
		#3ms;
		$display("timeout waiting on the core");
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic send_item(tchc_req_t r);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req_valid <= 1'b1;
		req       <= r;
		@(negedge clk);
		while (req_stall)
			@(negedge clk);
		sb.note_request(r);
		items_sent++;
		@(posedge clk);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_beat(logic [1:0] idx, logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		while (!cfg_ready)
			@(negedge clk);
		sb.set_register(idx, data);
		@(posedge clk);
	endtask

	// upper data bits are random to show they are dropped
	task automatic apply_settings(logic [30:0] mp, logic [15:0] noz, logic [30:0] mtr);
		cfg_beat(REG_MAX_PUSH, {$urandom_range(0, 1) == 1, mp});
		cfg_beat(REG_NOZZLE_OFFSET, {16'($urandom), noz});
		cfg_beat(REG_MAX_TURN_RATE, {$urandom_range(0, 1) == 1, mtr});
		cfg_beat(REG_UNUSED, $urandom);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] ranged_word();
		return $urandom >> $urandom_range(0, 31);
	endfunction

	function automatic tchc_req_t random_body();
		tchc_req_t r;
		r.steer_x      = ($urandom_range(0, 1) == 1) ? -ranged_word() : ranged_word();
		r.steer_y      = ($urandom_range(0, 1) == 1) ? -ranged_word() : ranged_word();
		r.body_mass    = 31'(ranged_word());
		r.body_heading = 16'($urandom);
		r.spin_rate    = ($urandom_range(0, 1) == 1) ? -ranged_word() : ranged_word();
		r.body_inertia = 31'(ranged_word());
		if ($urandom_range(0, 15) == 0) begin
			r.steer_x = 0;
			r.steer_y = 0;
		end
		return r;
	endfunction

	function automatic tchc_req_t make_body(logic signed [31:0] sx, logic signed [31:0] sy,
			logic [30:0] m, logic [15:0] h, logic signed [31:0] w, logic [30:0] j);
		tchc_req_t r;
		r.steer_x      = sx;
		r.steer_y      = sy;
		r.body_mass    = m;
		r.body_heading = h;
		r.spin_rate    = w;
		r.body_inertia = j;
		return r;
	endfunction

	initial begin : stimulus
		logic [30:0] ONE_Q16;
		int          phase;
		ONE_Q16    = 31'h1_0000;
		sb         = new();
		hold_go    = 0;
		burst_left = 0;
		items_sent = 0;
		arst_n     = 1'b0;
		req_valid  = 1'b0;
		req        = '0;
		cfg_valid  = 1'b0;
		cfg_index  = REG_MAX_PUSH;
		cfg_data   = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// all registers at zero: zero max push and zero turn clamp
		apply_settings('0, '0, '0);
		send_item(make_body(0, 0, 0, 0, 0, 0));
		send_item(make_body(32'sh0001_0000, 32'sh0002_0000, ONE_Q16, 16'h1234, 0, ONE_Q16));
		send_item(make_body(32'sh7FFF_FFFF, 32'sh8000_0000, 31'h7FFF_FFFF, 16'hFFFF,
			32'sh7FFF_FFFF, 31'h7FFF_FFFF));
		drain();

		apply_settings(31'd100 << 16, 16'h4000, 31'h7FFF_FFFF);
		send_item(make_body(0, 0, ONE_Q16, 16'hC000, 0, ONE_Q16));
		send_item(make_body(0, 0, ONE_Q16, 16'h4000, 0, 31'h7FFF_FFFF));
		send_item(make_body(32'sh0003_0000, 32'sh0004_0000, ONE_Q16, 0, 0, ONE_Q16));
		send_item(make_body(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 16'hFFFF,
			32'sh8000_0000, 31'h7FFF_FFFF));
		send_item(make_body(32'sh8000_0000, 32'sh8000_0000, 31'h7FFF_FFFF, 0,
			32'sh7FFF_FFFF, 31'h7FFF_FFFF));
		send_item(make_body(32'sh8000_0000, 0, ONE_Q16, 16'h8000, -3, 1));
		send_item(make_body(0, 32'sh7FFF_FFFF, 0, 16'h0001, 3, 0));
		send_item(make_body(-32'sh0001_0000, 1, ONE_Q16 << 4, 16'h7FFF, -32'sh0001_0000,
			ONE_Q16));
		send_item(make_body(32'sh0050_0000, -32'sh0050_0000, ONE_Q16, 16'h2000,
			32'sh0000_0002, ONE_Q16 << 8));
		send_item(make_body(-1, -1, 31'h7FFF_FFFF, 16'hFFFF, -1, 31'h7FFF_FFFF));
		send_item(make_body(32'sh0064_0000, 0, ONE_Q16, 16'h4000, 0, ONE_Q16));
		drain();

		apply_settings(31'h7FFF_FFFF, 16'hFFFF, 31'd1);
		send_item(make_body(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 0,
			32'sh7FFF_FFFF, 31'h7FFF_FFFF));
		send_item(make_body(0, 0, ONE_Q16, 16'h7FFF, 0, 31'h7FFF_FFFF));
		send_item(make_body(32'sh0001_0000, 32'sh8000_0000, 1, 16'h8000,
			32'sh8000_0000, 31'h7FFF_FFFF));
		drain();

		for (phase = 0; phase < 6; phase++) begin
			case (phase)
				0: apply_settings(31'($urandom) >> 8, 16'($urandom), 31'($urandom) >> 4);
				1: apply_settings('0, 16'hFFFF, 31'h7FFF_FFFF);
				2: apply_settings(31'h7FFF_FFFF, '0, '0);
				3: apply_settings(31'($urandom), 16'($urandom), 31'($urandom));
				4: apply_settings(31'($urandom) >> $urandom_range(0, 30), 16'($urandom),
					31'($urandom) >> $urandom_range(0, 30));
				default: apply_settings(31'd1, 16'h8000, 31'($urandom) >> 12);
			endcase
			if (phase == 3)
				hold_go = 1;
			// the held phase offers more beats than the pipeline holds
			repeat ((phase == 3) ? 140 : 50)
				send_item(random_body());
			drain();
		end

		$display("%0d bodies sent over 9 register settings, %0d results checked, %0d clamped",
			items_sent, sb.checked, sb.clamped);
		$display("covered zero and full-range push and turn limits, input backpressure");
		if (sb.mismatches == 0 && sb.expected_q.size() == 0)
			$display("[ OK ] regression clean");
		else begin
			$display("%0d mismatches, %0d results missing", sb.mismatches, sb.expected_q.size());
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/tchc_pkg.sv
hdl/tchc_isqrt.sv
hdl/tchc_div.sv
hdl/tchc_heading.sv
hdl/thrust_clamp_heading_control_core.sv
hdl/tchc_checker.sv
tb/tb_top.sv
